@@ rtl/msg_pkg.sv @@
// Shared types and constants of the motor stall guard.
`timescale 1ns / 1ps
`default_nettype none

package msg_pkg;

  // Field and register widths.
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned NUM_W   = 36;  // scale * current * 16
  localparam int unsigned DEN_W   = 32;  // command * battery
  localparam int unsigned QUO_W   = 16;  // quotient bits produced by the divider
  localparam int unsigned STEP_W  = 5;   // divider step counter
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_RATIO_SCALE     = 3'd0;
  localparam logic [2:0] REG_MIN_COMMAND     = 3'd1;
  localparam logic [2:0] REG_RATIO_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_CURRENT_FLOOR   = 3'd3;
  localparam logic [2:0] REG_DETECT_TICKS    = 3'd4;
  localparam logic [2:0] REG_SHORT_TICKS     = 3'd5;
  localparam logic [2:0] REG_LONG_TICKS      = 3'd6;
  localparam logic [2:0] REG_COMMAND_MARGIN  = 3'd7;

  // Status codes reported with each result.
  localparam logic [1:0] STATUS_WORKING     = 2'd0;
  localparam logic [1:0] STATUS_SHORT_STALL = 2'd1;
  localparam logic [1:0] STATUS_LONG_STALL  = 2'd2;

  // Direction codes.
  localparam logic [1:0] DIR_CLOSE = 2'b01;
  localparam logic [1:0] DIR_OPEN  = 2'b11;

  // Grip cycle phases.
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_CLOSING = 2'd1;
  localparam logic [1:0] PHASE_GRIPPED = 2'd2;
  localparam logic [1:0] PHASE_DONE    = 2'd3;

  // Configuration register set.
  typedef struct packed {
    logic [VAL_W-1:0] ratio_scale;
    logic [VAL_W-1:0] min_command;
    logic [VAL_W-1:0] ratio_threshold;
    logic [VAL_W-1:0] current_floor;
    logic [VAL_W-1:0] detect_ticks;
    logic [VAL_W-1:0] short_ticks;
    logic [VAL_W-1:0] long_ticks;
    logic [VAL_W-1:0] command_margin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ratio_scale:     16'd256,
    min_command:     16'd128,
    ratio_threshold: 16'd3686,
    current_floor:   16'd500,
    detect_ticks:    16'd10,
    short_ticks:     16'd100,
    long_ticks:      16'd1000,
    command_margin:  16'd256
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic mul;        // form the products
    logic div_start;  // launch the divider
    logic ring_upd;   // store the ratio and update the ring sum
    logic avg;        // capture the moving average of the ring
    logic finish;     // run the stall logic and load the result word
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/msg_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module msg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/msg_div.sv @@
// Restoring divider that produces a 16-bit quotient one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msg_div
  import msg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic                  sat_o,
  output logic      [QUO_W-1:0] quo_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [QUO_W-1:0]  low_q, low_d;
  logic              sat_q, sat_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // One quotient bit per step: shift in the next numerator bit, try to subtract.
  always_comb begin
    trial = {rem_q, low_q[QUO_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    sat_d  = sat_q;
    if (start_i) begin
      // The upper numerator bits start as the partial remainder; when they
      // already reach the divisor the quotient does not fit in 16 bits.
      busy_d = 1'b1;
      cnt_d  = STEP_W'(QUO_W);
      rem_d  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      low_d  = num_i[QUO_W-1:0];
      den_d  = den_i;
      sat_d  = (DEN_W'(num_i[NUM_W-1:QUO_W]) >= den_i);
    end else if (busy_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_d = {low_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quo_o  = low_q;

endmodule

`default_nettype wire

@@ rtl/msg_datapath.sv @@
// Datapath: products, ratio ring, moving average and stall bookkeeping.
`timescale 1ns / 1ps
`default_nettype none

module msg_datapath
  import msg_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_stat_t              stat_o,
  input  wire logic [VAL_W-1:0] applied_command_i,
  input  wire logic [VAL_W-1:0] requested_command_i,
  input  wire logic signed [1:0] direction_i,
  input  wire logic             dir_changed_i,
  input  wire logic [VAL_W-1:0] current_level_i,
  input  wire logic [VAL_W-1:0] battery_level_i,
  output logic      [1:0]       status_o,
  output logic                  stop_motor_o,
  output logic      [VAL_W-1:0] ratio_average_o,
  output logic      [VAL_W-1:0] direction_changes_o,
  output logic      [VAL_W-1:0] grip_cycles_o,
  output logic                  counts_updated_o
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned LOG_D = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W = VAL_W + LOG_D;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [VAL_W-1:0] VAL_MAX  = '1;

  // Exact floor division of the ring sum by the depth: multiply by the rounded-up
  // reciprocal and shift. One extra bit over the sum width keeps it exact.
  localparam int unsigned MEAN_SH = SUM_W + LOG_D;
  localparam int unsigned RCP_W   = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] MEAN_RCP =
    RCP_W'(((64'd1 << MEAN_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

  // Captured input word.
  logic [VAL_W-1:0] applied_q, requested_q, current_q, battery_q;
  logic [1:0]       dir_q;
  logic             changed_q;

  // Products.
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] lim_new_q;  // margin times this tick's command
  logic [DEN_W-1:0] lim_old_q;  // margin times the stored stall command
  logic             zero_q;

  // Ring and moving average.
  logic [PTR_W-1:0]  ptr_q;
  logic              full_q;
  logic [SUM_W-1:0]  sum_q;
  logic [VAL_W-1:0]  ring_rdata;
  logic [VAL_W-1:0]  old_ratio;
  logic [VAL_W-1:0]  ratio;
  logic [PROD_W-1:0] mean_prod;
  logic [VAL_W-1:0]  mean_q;

  // Stall and grip state.
  logic [VAL_W-1:0] det_q, st_q, last_q, chg_q, cyc_q;
  logic             act_q;
  logic [1:0]       phase_q;

  // Result word.
  logic [1:0]       status_q;
  logic             stop_q;
  logic [VAL_W-1:0] avg_q;
  logic             upd_q;

  // Divider.
  logic             div_done, div_sat;
  logic [QUO_W-1:0] div_quo;

  // Next-state of the stall logic.
  logic             closing, opening, over, stall_hit;
  logic [VAL_W-1:0] det1, det2, st1, last1, chg1, cyc1;
  logic             act1, stop1, upd1;
  logic [1:0]       status1, ph1;
  logic [DEN_W-1:0] limit;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      applied_q   <= applied_command_i;
      requested_q <= requested_command_i;
      dir_q       <= direction_i;
      changed_q   <= dir_changed_i;
      current_q   <= current_level_i;
      battery_q   <= battery_level_i;
    end
  end

  // Products for the ratio and for the restart test.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q     <= (NUM_W'(cfg_i.ratio_scale) * NUM_W'(current_q)) << 4;
      den_q     <= DEN_W'(applied_q) * DEN_W'(battery_q);
      lim_new_q <= DEN_W'(cfg_i.command_margin) * DEN_W'(applied_q);
      lim_old_q <= DEN_W'(cfg_i.command_margin) * DEN_W'(last_q);
      zero_q    <= (applied_q <= cfg_i.min_command) || (battery_q == '0);
    end
  end

  msg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .sat_o  (div_sat),
    .quo_o  (div_quo)
  );

  assign stat_o.div_done = div_done;

  // Ring storage; entries not yet written since reset read as zero.
  msg_ram #(
    .WIDTH(VAL_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ring_upd),
    .waddr_i(ptr_q),
    .wdata_i(ratio),
    .raddr_i(ptr_q),
    .rdata_o(ring_rdata)
  );

  assign old_ratio = full_q ? ring_rdata : '0;
  assign ratio     = zero_q ? '0 : (div_sat ? VAL_MAX : div_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else if (cmd_i.ring_upd) begin
      sum_q <= sum_q - SUM_W'(old_ratio) + SUM_W'(ratio);
      if (ptr_q == PTR_LAST) begin
        ptr_q  <= '0;
        full_q <= 1'b1;
      end else begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  // Moving average, captured the cycle after the ring sum is updated.
  assign mean_prod = PROD_W'(sum_q) * PROD_W'(MEAN_RCP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg) begin
      mean_q <= mean_prod[MEAN_SH +: VAL_W];
    end
  end

  // Stall detection, stall timing, restart test and grip counting.
  always_comb begin
    closing   = (dir_q == DIR_CLOSE);
    opening   = (dir_q == DIR_OPEN);
    over      = (mean_q > cfg_i.ratio_threshold) && (current_q > cfg_i.current_floor);
    det1      = over ? ((det_q == VAL_MAX) ? det_q : det_q + VAL_W'(1)) : '0;
    act1      = act_q;
    st1       = st_q;
    last1     = last_q;
    ph1       = phase_q;
    stall_hit = (det1 >= cfg_i.detect_ticks);
    if (stall_hit) begin
      act1  = 1'b1;
      st1   = '0;
      last1 = applied_q;
      if ((phase_q == PHASE_CLOSING) && closing) begin
        ph1 = PHASE_GRIPPED;
      end
    end else if (act_q) begin
      st1 = (st_q == VAL_MAX) ? st_q : st_q + VAL_W'(1);
    end
    if (st1 >= cfg_i.long_ticks) begin
      act1 = 1'b0;
    end

    limit   = stall_hit ? lim_new_q : lim_old_q;
    det2    = det1;
    stop1   = 1'b0;
    status1 = STATUS_WORKING;
    if (act1) begin
      if (st1 < cfg_i.short_ticks) begin
        stop1   = 1'b1;
        status1 = STATUS_SHORT_STALL;
      end else begin
        status1 = STATUS_LONG_STALL;
        det2    = '0;
        stop1   = !changed_q && (DEN_W'({requested_q, 8'h00}) < limit);
      end
    end

    chg1 = chg_q;
    cyc1 = cyc_q;
    upd1 = 1'b0;
    if (changed_q) begin
      if (closing) begin
        chg1 = chg_q + VAL_W'(1);
        upd1 = 1'b1;
      end
      if (((ph1 == PHASE_IDLE) && closing) || ((ph1 == PHASE_GRIPPED) && opening)) begin
        ph1 = ph1 + 2'd1;
      end
    end
    if (ph1 == PHASE_DONE) begin
      ph1  = PHASE_IDLE;
      cyc1 = cyc_q + VAL_W'(1);
      upd1 = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q   <= '0;
      st_q    <= '0;
      act_q   <= 1'b0;
      last_q  <= '0;
      phase_q <= PHASE_IDLE;
      chg_q   <= '0;
      cyc_q   <= '0;
    end else if (cmd_i.finish) begin
      det_q   <= det2;
      st_q    <= st1;
      act_q   <= act1;
      last_q  <= last1;
      phase_q <= ph1;
      chg_q   <= chg1;
      cyc_q   <= cyc1;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status1;
      stop_q   <= stop1;
      avg_q    <= mean_q;
      upd_q    <= upd1;
    end
  end

  assign status_o            = status_q;
  assign stop_motor_o        = stop_q;
  assign ratio_average_o     = avg_q;
  assign direction_changes_o = chg_q;
  assign grip_cycles_o       = cyc_q;
  assign counts_updated_o    = upd_q;

endmodule

`default_nettype wire

@@ rtl/msg_ctrl.sv @@
// Controller: sequences one word through the datapath and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module msg_ctrl
  import msg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dp_cmd_t       cmd_o,
  input  wire dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RSTART,
    ST_RWAIT,
    ST_RING,
    ST_AVG,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Command decode from the current state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.div_start = (state_q == ST_RSTART);
    cmd_o.ring_upd  = (state_q == ST_RING);
    cmd_o.avg       = (state_q == ST_AVG);
    cmd_o.finish    = (state_q == ST_FIN) && slot_free;
  end

  // State register and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result word takes the slot; otherwise an accepted word frees it.
      if ((state_q == ST_FIN) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:    state_q <= ST_RSTART;
        ST_RSTART: state_q <= ST_RWAIT;
        ST_RWAIT: begin
          if (stat_i.div_done) begin
            state_q <= ST_RING;
          end
        end
        ST_RING:   state_q <= ST_AVG;
        ST_AVG:    state_q <= ST_FIN;
        ST_FIN: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/motor_stall_guard.sv @@
// Top level of the motor stall guard: configuration registers, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Motor stall guard. Each input word is one control tick: the block forms the
// load ratio scale*current*16/(command*battery) in Q4.12, keeps a moving average
// over RING_DEPTH ticks, and reports stall status, a stop flag and two event
// counts in one result word. For each word the block captures it, forms the
// products, starts the restoring divider that forms the ratio, sees it finish,
// updates the ring, forms the average with a reciprocal multiply and loads the
// result; only then can it accept the next word. The result register holds the
// previous word while the next one is computed, so a stalled output does not
// block input until a second result is ready. The registers must be written by
// the user over the APB port only while no word is in flight; the block itself
// does not enforce this.

module motor_stall_guard
  import msg_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // Input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [VAL_W-1:0]   applied_command_i,
  input  wire logic [VAL_W-1:0]   requested_command_i,
  input  wire logic signed [1:0]  direction_i,
  input  wire logic               dir_changed_i,
  input  wire logic [VAL_W-1:0]   current_level_i,
  input  wire logic [VAL_W-1:0]   battery_level_i,
  // Output channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [1:0]         status_o,
  output logic                    stop_motor_o,
  output logic      [VAL_W-1:0]   ratio_average_o,
  output logic      [VAL_W-1:0]   direction_changes_o,
  output logic      [VAL_W-1:0]   grip_cycles_o,
  output logic                    counts_updated_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic [VAL_W-1:0] rd_val;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RATIO_SCALE:     cfg_q.ratio_scale     <= pwdata[VAL_W-1:0];
        REG_MIN_COMMAND:     cfg_q.min_command     <= pwdata[VAL_W-1:0];
        REG_RATIO_THRESHOLD: cfg_q.ratio_threshold <= pwdata[VAL_W-1:0];
        REG_CURRENT_FLOOR:   cfg_q.current_floor   <= pwdata[VAL_W-1:0];
        REG_DETECT_TICKS:    cfg_q.detect_ticks    <= pwdata[VAL_W-1:0];
        REG_SHORT_TICKS:     cfg_q.short_ticks     <= pwdata[VAL_W-1:0];
        REG_LONG_TICKS:      cfg_q.long_ticks      <= pwdata[VAL_W-1:0];
        REG_COMMAND_MARGIN:  cfg_q.command_margin  <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_RATIO_SCALE:     rd_val = cfg_q.ratio_scale;
      REG_MIN_COMMAND:     rd_val = cfg_q.min_command;
      REG_RATIO_THRESHOLD: rd_val = cfg_q.ratio_threshold;
      REG_CURRENT_FLOOR:   rd_val = cfg_q.current_floor;
      REG_DETECT_TICKS:    rd_val = cfg_q.detect_ticks;
      REG_SHORT_TICKS:     rd_val = cfg_q.short_ticks;
      REG_LONG_TICKS:      rd_val = cfg_q.long_ticks;
      REG_COMMAND_MARGIN:  rd_val = cfg_q.command_margin;
      default:             rd_val = '0;
    endcase
  end

  assign prdata = PDATA_W'(rd_val);

  msg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  msg_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .applied_command_i  (applied_command_i),
    .requested_command_i(requested_command_i),
    .direction_i        (direction_i),
    .dir_changed_i      (dir_changed_i),
    .current_level_i    (current_level_i),
    .battery_level_i    (battery_level_i),
    .status_o           (status_o),
    .stop_motor_o       (stop_motor_o),
    .ratio_average_o    (ratio_average_o),
    .direction_changes_o(direction_changes_o),
    .grip_cycles_o      (grip_cycles_o),
    .counts_updated_o   (counts_updated_o)
  );

endmodule

`default_nettype wire

@@ rtl/msg_checker.sv @@
// Port-level checker for the motor stall guard, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module msg_checker
  import msg_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [1:0]       status_o,
  input wire logic             stop_motor_o,
  input wire logic [VAL_W-1:0] ratio_average_o
);

  // An accepted word keeps the input side busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a word was accepted");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(stop_motor_o) &&
       $stable(ratio_average_o)))
    else $error("stalled result word changed");

  // Only the three defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_WORKING || status_o == STATUS_SHORT_STALL ||
                     status_o == STATUS_LONG_STALL))
    else $error("undefined status code");

  // A short stall always stops the motor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_SHORT_STALL) |-> stop_motor_o)
    else $error("short stall without stop");

  // Outside a stall the motor is never stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_WORKING) |-> !stop_motor_o)
    else $error("stop raised while working");

endmodule

bind motor_stall_guard msg_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .stop_motor_o   (stop_motor_o),
  .ratio_average_o(ratio_average_o)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the motor stall guard: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_top;
  import msg_pkg::*;

  localparam int RING_N = 8;

  // Direction codes that the package does not name.
  localparam logic [1:0] DIR_IDLE     = 2'b00;
  localparam logic [1:0] DIR_RESERVED = 2'b10;

  // One control tick as offered to the block.
  typedef struct packed {
    logic [VAL_W-1:0] applied;
    logic [VAL_W-1:0] requested;
    logic [1:0]       direction;
    logic             changed;
    logic [VAL_W-1:0] current;
    logic [VAL_W-1:0] battery;
  } tick_t;

  // One result word of the block.
  typedef struct packed {
    logic [1:0]       status;
    logic             stop;
    logic [VAL_W-1:0] average;
    logic [VAL_W-1:0] changes;
    logic [VAL_W-1:0] cycles;
    logic             updated;
  } guard_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] applied_command = '0;
  logic [VAL_W-1:0] requested_command = '0;
  logic [1:0]       direction = '0;
  logic             dir_changed = 1'b0;
  logic [VAL_W-1:0] current_level = '0;
  logic [VAL_W-1:0] battery_level = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic             stop_motor;
  logic [VAL_W-1:0] ratio_average;
  logic [VAL_W-1:0] direction_changes;
  logic [VAL_W-1:0] grip_cycles;
  logic             counts_updated;

  motor_stall_guard #(.RING_DEPTH(RING_N)) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .applied_command_i   (applied_command),
    .requested_command_i (requested_command),
    .direction_i         (direction),
    .dir_changed_i       (dir_changed),
    .current_level_i     (current_level),
    .battery_level_i     (battery_level),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status),
    .stop_motor_o        (stop_motor),
    .ratio_average_o     (ratio_average),
    .direction_changes_o (direction_changes),
    .grip_cycles_o       (grip_cycles),
    .counts_updated_o    (counts_updated)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus and expectation stores.
  tick_t       tick_backlog[$];
  guard_word_t guard_words_due[$];
  tick_t       offered;

  // Run control shared by the processes.
  int ticks_accepted = 0;
  int hold_mark = 32'h7fff_ffff;
  bit calm = 1'b0;
  int fill_count;
  int settings_count = 0;

  // Run statistics.
  int fault_count = 0;
  int words_checked = 0;
  int short_words = 0;
  int long_words = 0;
  int stop_words = 0;
  logic [VAL_W-1:0] last_grip_count = '0;

  // Predictor state and its copy of the registers.
  cfg_t             gcfg = CFG_RESET;
  logic [VAL_W-1:0] load_ring[RING_N];
  int               ring_slot = 0;
  logic [18:0]      load_sum = '0;
  logic [VAL_W-1:0] over_count = '0;
  logic [VAL_W-1:0] since_stall = '0;
  bit               stalled = 1'b0;
  logic [VAL_W-1:0] stall_command = '0;
  logic [1:0]       grip_phase = PHASE_IDLE;
  logic [VAL_W-1:0] close_count = '0;
  logic [VAL_W-1:0] grip_count = '0;

  initial begin
    foreach (load_ring[i]) load_ring[i] = '0;
  end

  // Advance the predicted guard by one tick and return the word it must report.
  function automatic guard_word_t advance_guard(input tick_t t);
    guard_word_t r;
    logic [63:0] num, den, quo;
    logic [VAL_W-1:0] ratio;
    logic [31:0] ask, floor_cmd;
    bit closing, opening;
    r = '0;
    closing = (t.direction == DIR_CLOSE);
    opening = (t.direction == DIR_OPEN);

    // Load ratio in Q4.12, saturating, zero when the command or battery is too low.
    if (t.applied <= gcfg.min_command || t.battery == '0) begin
      ratio = '0;
    end else begin
      num = 64'(gcfg.ratio_scale) * 64'(t.current) * 64'd16;
      den = 64'(t.applied) * 64'(t.battery);
      quo = num / den;
      ratio = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
    end

    // Moving average over the ring.
    load_sum = load_sum - 19'(load_ring[ring_slot]) + 19'(ratio);
    load_ring[ring_slot] = ratio;
    ring_slot = (ring_slot + 1) % RING_N;
    r.average = 16'(load_sum / RING_N);

    // Consecutive overload ticks, saturating.
    if (r.average > gcfg.ratio_threshold && t.current > gcfg.current_floor) begin
      if (over_count != 16'hFFFF) over_count = over_count + 16'd1;
    end else begin
      over_count = '0;
    end

    // Stall declaration and the timer that follows it.
    if (over_count >= gcfg.detect_ticks) begin
      stalled = 1'b1;
      since_stall = '0;
      stall_command = t.applied;
      if (grip_phase == PHASE_CLOSING && closing) grip_phase = PHASE_GRIPPED;
    end else if (stalled) begin
      if (since_stall != 16'hFFFF) since_stall = since_stall + 16'd1;
    end
    if (since_stall >= gcfg.long_ticks) stalled = 1'b0;

    // Short stall always stops; long stall stops unless a restart is allowed.
    r.status = STATUS_WORKING;
    if (stalled) begin
      if (since_stall < gcfg.short_ticks) begin
        r.stop = 1'b1;
        r.status = STATUS_SHORT_STALL;
      end else begin
        r.status = STATUS_LONG_STALL;
        over_count = '0;
        ask = 32'(t.requested) << 8;
        floor_cmd = 32'(gcfg.command_margin) * 32'(stall_command);
        if (!t.changed && ask < floor_cmd) r.stop = 1'b1;
      end
    end

    // Direction-change and grip-cycle counts.
    if (t.changed) begin
      if (closing) begin
        close_count = close_count + 16'd1;
        r.updated = 1'b1;
      end
      if ((grip_phase == PHASE_IDLE && closing) || (grip_phase == PHASE_GRIPPED && opening))
        grip_phase = grip_phase + 2'd1;
    end
    if (grip_phase == PHASE_DONE) begin
      grip_phase = PHASE_IDLE;
      grip_count = grip_count + 16'd1;
      r.updated = 1'b1;
    end
    r.changes = close_count;
    r.cycles = grip_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  // Driver: predicts each accepted word and offers the next one from the backlog.
  always @(posedge clk_i) begin : feed
    bit take_next;
    take_next = 1'b0;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        guard_words_due.push_back(advance_guard(offered));
        ticks_accepted <= ticks_accepted + 1;
        take_next = 1'b1;
      end else if (!in_valid) begin
        take_next = 1'b1;
      end
      if (take_next) begin
        if (tick_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
          offered = tick_backlog.pop_front();
          in_valid <= 1'b1;
          applied_command <= offered.applied;
          requested_command <= offered.requested;
          direction <= offered.direction;
          dir_changed <= offered.changed;
          current_level <= offered.current;
          battery_level <= offered.battery;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off once hold_mark is reached.
  always @(posedge clk_i) begin : drain_gate
    static int hold_left = 0;
    static bit hold_used = 1'b0;
    if (!hold_used && ticks_accepted >= hold_mark) begin
      hold_left = 400;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 31);
    end
  end

  // Monitor: compares each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : watch
    guard_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (guard_words_due.size() == 0) begin
        $error("result word arrived with no tick outstanding");
        fault_count++;
      end else begin
        want = guard_words_due.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("stop_motor", 16'(want.stop), 16'(stop_motor));
        check_field("ratio_average", want.average, ratio_average);
        check_field("direction_changes", want.changes, direction_changes);
        check_field("grip_cycles", want.cycles, grip_cycles);
        check_field("counts_updated", 16'(want.updated), 16'(counts_updated));
        words_checked++;
        if (want.status == STATUS_SHORT_STALL) short_words++;
        if (want.status == STATUS_LONG_STALL) long_words++;
        if (want.stop) stop_words++;
        last_grip_count = want.cycles;
      end
    end
  end

  function automatic tick_t tick_of(input int a, input int r, input logic [1:0] d,
                                    input logic c, input int i, input int b);
    tick_t t;
    t.applied = a[15:0];
    t.requested = r[15:0];
    t.direction = d;
    t.changed = c;
    t.current = i[15:0];
    t.battery = b[15:0];
    return t;
  endfunction

  function automatic void offer_tick(input tick_t t);
    tick_backlog.push_back(t);
    fill_count++;
  endfunction

  // Heavy ticks push the ratio far above any sensible threshold; light ones keep it low.
  function automatic tick_t shaped_tick(input bit heavy, input logic [1:0] d,
                                        input logic c, input int req);
    int cmd_lo, cmd_hi, cur_lo;
    tick_t t;
    cmd_lo = int'(gcfg.min_command) + 1;
    if (cmd_lo > 65535) cmd_lo = 65535;
    cmd_hi = (cmd_lo + 400 > 65535) ? 65535 : cmd_lo + 400;
    t.requested = req[15:0];
    t.direction = d;
    t.changed = c;
    if (heavy) begin
      cur_lo = int'(gcfg.current_floor) + 1;
      if (cur_lo < 20000) cur_lo = 20000;
      if (cur_lo > 65535) cur_lo = 65535;
      t.applied = 16'($urandom_range(cmd_lo, cmd_hi));
      t.battery = 16'($urandom_range(1, 3));
      t.current = 16'($urandom_range(cur_lo, 65535));
    end else begin
      t.applied = 16'($urandom_range(cmd_lo, 65535));
      t.battery = 16'($urandom_range(6000, 65535));
      t.current = 16'($urandom_range(0, 1500));
    end
    return t;
  endfunction

  // A grip: close, load up toward a stall, linger, then open. Some skip the load.
  task automatic queue_grip();
    int n_after, last_hi, req;
    longint need;
    bit broken;
    tick_t t;
    last_hi = 0;
    broken = ($urandom_range(0, 4) == 0);
    offer_tick(shaped_tick(1'b0, DIR_CLOSE, 1'b1, $urandom_range(0, 65535)));
    repeat ($urandom_range(0, 3))
      offer_tick(shaped_tick(1'b0, DIR_CLOSE, 1'b0, $urandom_range(0, 65535)));
    if (!broken) begin
      repeat ($urandom_range(2, 10)) begin
        t = shaped_tick(1'b1, DIR_CLOSE, 1'b0, $urandom_range(0, 65535));
        last_hi = int'(t.applied);
        offer_tick(t);
      end
    end
    // Requests straddle the restart limit so the exact compare is exercised.
    n_after = $urandom_range(0, (gcfg.long_ticks > 26) ? 30 : int'(gcfg.long_ticks) + 4);
    need = (longint'(gcfg.command_margin) * last_hi) / 256;
    repeat (n_after) begin
      req = int'(need) + $urandom_range(0, 4) - 2;
      if (req < 0) req = 0;
      if (req > 65535) req = 65535;
      offer_tick(shaped_tick(1'b0, DIR_CLOSE, $urandom_range(0, 7) == 0, req));
    end
    offer_tick(shaped_tick(1'b0, DIR_OPEN, 1'b1, $urandom_range(0, 65535)));
    repeat ($urandom_range(0, 3))
      offer_tick(shaped_tick(1'b0, DIR_OPEN, 1'b0, $urandom_range(0, 65535)));
  endtask

  task automatic fill_phase(input int n);
    fill_count = 0;
    while (fill_count < n) begin
      if ($urandom_range(0, 99) < 75) begin
        queue_grip();
      end else begin
        repeat ($urandom_range(1, 4))
          offer_tick(tick_of($urandom, $urandom, 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)), $urandom, $urandom));
      end
    end
  endtask

  // Block until every queued word has gone in and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_backlog.size() != 0 || in_valid || guard_words_due.size() != 0);
  endtask

  // APB write: setup cycle, access cycle, register written at the ready edge.
  task automatic write_reg(input logic [2:0] idx, input logic [VAL_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RATIO_SCALE:     gcfg.ratio_scale = val;
      REG_MIN_COMMAND:     gcfg.min_command = val;
      REG_RATIO_THRESHOLD: gcfg.ratio_threshold = val;
      REG_CURRENT_FLOOR:   gcfg.current_floor = val;
      REG_DETECT_TICKS:    gcfg.detect_ticks = val;
      REG_SHORT_TICKS:     gcfg.short_ticks = val;
      REG_LONG_TICKS:      gcfg.long_ticks = val;
      REG_COMMAND_MARGIN:  gcfg.command_margin = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_RATIO_SCALE, c.ratio_scale);
    write_reg(REG_MIN_COMMAND, c.min_command);
    write_reg(REG_RATIO_THRESHOLD, c.ratio_threshold);
    write_reg(REG_CURRENT_FLOOR, c.current_floor);
    write_reg(REG_DETECT_TICKS, c.detect_ticks);
    write_reg(REG_SHORT_TICKS, c.short_ticks);
    write_reg(REG_LONG_TICKS, c.long_ticks);
    write_reg(REG_COMMAND_MARGIN, c.command_margin);
    settings_count++;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input cfg_t c, input int n, input bit pause_mid);
    apply_cfg(c);
    if (pause_mid) begin
      fill_phase(n / 2);
      wait_drained();
      fill_phase(n - n / 2);
    end else begin
      fill_phase(n);
    end
    wait_drained();
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.ratio_scale = 16'($urandom_range(128, 1024));
    c.min_command = 16'($urandom_range(0, 300));
    c.ratio_threshold = 16'($urandom_range(1000, 8000));
    c.current_floor = 16'($urandom_range(0, 3000));
    c.detect_ticks = 16'($urandom_range(1, 6));
    c.short_ticks = 16'($urandom_range(0, 8));
    c.long_ticks = 16'($urandom_range(0, 40));
    c.command_margin = 16'($urandom_range(0, 512));
    return c;
  endfunction

  // Main sequence: reset, directed ticks, then random phases over several settings.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Field extremes, saturated ratio, a short then long stall, the restart limit
    // on both sides, restart by direction change, and the reserved direction code.
    apply_cfg('{16'd256, 16'd128, 16'd3686, 16'd500, 16'd2, 16'd2, 16'd6, 16'd256});
    offer_tick(tick_of(0, 0, DIR_IDLE, 1'b0, 0, 0));
    offer_tick(tick_of(65535, 65535, DIR_RESERVED, 1'b1, 65535, 65535));
    offer_tick(tick_of(129, 0, DIR_CLOSE, 1'b1, 65535, 1));
    offer_tick(tick_of(200, 0, DIR_CLOSE, 1'b0, 65535, 1));
    offer_tick(tick_of(256, 0, DIR_CLOSE, 1'b0, 100, 16));
    offer_tick(tick_of(256, 199, DIR_CLOSE, 1'b0, 100, 16));
    offer_tick(tick_of(256, 200, DIR_CLOSE, 1'b0, 100, 16));
    offer_tick(tick_of(256, 0, DIR_OPEN, 1'b1, 100, 16));
    // Average right at the threshold, then one tick that only moves the fraction.
    repeat (8) offer_tick(tick_of(256, 65535, DIR_IDLE, 1'b0, 3686, 16));
    offer_tick(tick_of(256, 65535, DIR_IDLE, 1'b0, 3687, 16));
    wait_drained();

    // Stall on every tick that ends at once.
    apply_cfg('{16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF});
    offer_tick(tick_of(300, 0, DIR_CLOSE, 1'b1, 1000, 100));
    offer_tick(tick_of(300, 0, DIR_CLOSE, 1'b0, 1000, 100));
    offer_tick(tick_of(300, 0, DIR_OPEN, 1'b1, 1000, 100));
    offer_tick(tick_of(300, 65535, DIR_IDLE, 1'b1, 1000, 100));
    wait_drained();

    // Random phases.
    calm = 1'b1;
    run_phase('{16'd256, 16'd128, 16'd3686, 16'd500, 16'd3, 16'd4, 16'd20, 16'd256}, 150,
              1'b0);
    calm = 1'b0;
    run_phase('{default: 16'hFFFF}, 60, 1'b0);
    run_phase('0, 60, 1'b0);
    run_phase(random_cfg(), 150, 1'b1);
    hold_mark = ticks_accepted + 30;
    run_phase(random_cfg(), 150, 1'b0);
    run_phase(CFG_RESET, 130, 1'b0);
    run_phase(random_cfg(), 130, 1'b0);

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Checked %0d ticks over %0d register settings.", words_checked, settings_count);
    $display("Saw %0d short-stall and %0d long-stall words, %0d stops, %0d grip cycles.",
             short_words, long_words, stop_words, last_grip_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/msg_pkg.sv
rtl/msg_ram.sv
rtl/msg_div.sv
rtl/msg_datapath.sv
rtl/msg_ctrl.sv
rtl/motor_stall_guard.sv
rtl/msg_checker.sv
bench/tb_top.sv
